@@ rtl/core/kmcr_pkg.sv @@
package kmcr_pkg;

    // Matrix geometry limits and defaults
    localparam int MAX_ROWS          = 5;
    localparam int MAX_COLS          = 3;
    localparam int ROW_COUNT_DEFAULT = 5;
    localparam int COL_COUNT_DEFAULT = 3;

    // Field widths
    localparam int ROW_W       = 5;
    localparam int CODE_W      = 8;
    localparam int KEYMAP_W    = 40;
    localparam int ROW_IDX_W   = 3;
    localparam int COL_IDX_W   = 2;
    localparam int CFG_INDEX_W = 2;

    typedef logic [ROW_W-1:0]    rows_t;
    typedef logic [KEYMAP_W-1:0] keymap_t;
    typedef logic [CODE_W-1:0]   code_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYMAP_COLUMN0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYMAP_COLUMN1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYMAP_COLUMN2 = 2'd2;

    // Keymap defaults after reset
    localparam keymap_t KEYMAP_COLUMN0_RESET = 40'h6A0C690023;
    localparam keymap_t KEYMAP_COLUMN1_RESET = 40'h000D1E2D00;
    localparam keymap_t KEYMAP_COLUMN2_RESET = 40'h002E2C3000;

    // Home key polarity mode
    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_INVERT    = 2'd1,
        MODE_NORMAL    = 2'd2
    } mode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
    } kmcr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic any_change;
        logic rest_empty;
        logic out_busy;
    } kmcr_status_t;

endpackage

@@ rtl/core/keypad_matrix_change_reporter.sv @@
// Events are presented in walk order, column-major from position 0; an output
// stall holds the walk.
// A scan with no mapped change leaves the block idle; otherwise the block walks
// min(COLUMN_COUNT, 3) * min(ROW_COUNT, 5) positions, one per cycle while the output
// side has room, up to the last change, and takes no new item until the walk ends.
// Reset clears the scan history and the home polarity mode and restores the keymaps.
module keypad_matrix_change_reporter #(
    parameter int ROW_COUNT    = kmcr_pkg::ROW_COUNT_DEFAULT,
    parameter int COLUMN_COUNT = kmcr_pkg::COL_COUNT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kmcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kmcr_pkg::KEYMAP_W-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [kmcr_pkg::ROW_W-1:0]       rows_column0,
    input  logic [kmcr_pkg::ROW_W-1:0]       rows_column1,
    input  logic [kmcr_pkg::ROW_W-1:0]       rows_column2,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [kmcr_pkg::CODE_W-1:0]      key_code,
    output logic                             pressed,
    output logic                             last_event
);
    import kmcr_pkg::*;

    kmcr_cmd_t    cmd;
    kmcr_status_t status;

    // Registers take writes at any time
    assign cfg_ready = 1'b1;

    kmcr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kmcr_datapath #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rows_column0 (rows_column0),
        .rows_column1 (rows_column1),
        .rows_column2 (rows_column2),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .key_code     (key_code),
        .pressed      (pressed),
        .last_event   (last_event)
    );

endmodule

@@ rtl/core/kmcr_datapath.sv @@
module kmcr_datapath #(
    parameter int ROW_COUNT    = kmcr_pkg::ROW_COUNT_DEFAULT,
    parameter int COLUMN_COUNT = kmcr_pkg::COL_COUNT_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [kmcr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kmcr_pkg::KEYMAP_W-1:0]         cfg_data,
    input  logic [kmcr_pkg::ROW_W-1:0]            rows_column0,
    input  logic [kmcr_pkg::ROW_W-1:0]            rows_column1,
    input  logic [kmcr_pkg::ROW_W-1:0]            rows_column2,
    input  kmcr_pkg::kmcr_cmd_t                   cmd,
    output kmcr_pkg::kmcr_status_t                status,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [kmcr_pkg::CODE_W-1:0]           key_code,
    output logic                                  pressed,
    output logic                                  last_event
);
    import kmcr_pkg::*;

    localparam int WALK_ROWS = (ROW_COUNT < MAX_ROWS) ? ROW_COUNT : MAX_ROWS;
    localparam int WALK_COLS = (COLUMN_COUNT < MAX_COLS) ? COLUMN_COUNT : MAX_COLS;
    localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(WALK_ROWS - 1);

    keymap_t               keymap_reg [MAX_COLS];
    rows_t                 prev_reg   [MAX_COLS];
    rows_t                 pend_reg   [MAX_COLS];
    mode_t                 mode_reg;
    logic [ROW_IDX_W-1:0]  row_reg;
    logic [COL_IDX_W-1:0]  col_reg;
    logic                  out_valid_reg;
    code_t                 key_code_reg;
    logic                  pressed_reg;
    logic                  last_reg;

    rows_t                 scan       [MAX_COLS];
    rows_t                 load_pend  [MAX_COLS];
    rows_t                 rest_pend  [MAX_COLS];
    mode_t                 mode_next;
    logic                  cur_bit;
    logic                  any_change;
    logic                  rest_empty;

    // Correct home key polarity on the incoming scan
    always_comb
    begin
        scan[0]   = rows_column0;
        scan[1]   = rows_column1;
        scan[2]   = rows_column2;
        mode_next = mode_reg;
        case (mode_reg)
            MODE_UNDECIDED:
            begin
                mode_next  = rows_column0[0] ? MODE_INVERT : MODE_NORMAL;
                scan[0][0] = 1'b0;
            end
            MODE_INVERT:
            begin
                scan[0][0] = ~rows_column0[0];
            end
            default:
            begin
                scan[0][0] = rows_column0[0];
            end
        endcase
    end

    // Mark mapped positions that changed
    always_comb
    begin
        any_change = 1'b0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            for (int r = 0; r < ROW_W; r++)
            begin
                load_pend[c][r] = (c < WALK_COLS) && (r < WALK_ROWS)
                                  && (scan[c][r] != prev_reg[c][r])
                                  && (keymap_reg[c][r*CODE_W +: CODE_W] != '0);
                any_change      = any_change | load_pend[c][r];
            end
        end
    end

    // Drop the current position and check what remains
    always_comb
    begin
        cur_bit    = pend_reg[col_reg][row_reg];
        rest_empty = 1'b1;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            rest_pend[c] = pend_reg[c];
        end
        rest_pend[col_reg][row_reg] = 1'b0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            rest_empty = rest_empty & (rest_pend[c] == '0);
        end
    end

    assign status.any_change = any_change;
    assign status.rest_empty = rest_empty;
    assign status.out_busy   = out_valid_reg & out_stall;

    // Control and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keymap_reg[0] <= KEYMAP_COLUMN0_RESET;
            keymap_reg[1] <= KEYMAP_COLUMN1_RESET;
            keymap_reg[2] <= KEYMAP_COLUMN2_RESET;
            for (int c = 0; c < MAX_COLS; c++)
            begin
                prev_reg[c] <= '0;
                pend_reg[c] <= '0;
            end
            mode_reg      <= MODE_UNDECIDED;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEYMAP_COLUMN0: keymap_reg[0] <= cfg_data;
                    CFG_KEYMAP_COLUMN1: keymap_reg[1] <= cfg_data;
                    CFG_KEYMAP_COLUMN2: keymap_reg[2] <= cfg_data;
                    default:            ;
                endcase
            end

            if (cmd.load)
            begin
                mode_reg <= mode_next;
                for (int c = 0; c < MAX_COLS; c++)
                begin
                    pend_reg[c] <= load_pend[c];
                    if (c < WALK_COLS)
                    begin
                        prev_reg[c] <= scan[c];
                    end
                end
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (cmd.step)
            begin
                for (int c = 0; c < MAX_COLS; c++)
                begin
                    pend_reg[c] <= rest_pend[c];
                end
                if (row_reg == LAST_ROW)
                begin
                    row_reg <= '0;
                    col_reg <= col_reg + 1'b1;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end

            if (cmd.step && cur_bit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the event for the current position
    always_ff @(posedge clk)
    begin
        if (cmd.step && cur_bit)
        begin
            key_code_reg <= keymap_reg[col_reg][row_reg*CODE_W +: CODE_W];
            pressed_reg  <= prev_reg[col_reg][row_reg];
            last_reg     <= rest_empty;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_code   = key_code_reg;
    assign pressed    = pressed_reg;
    assign last_event = last_reg;

endmodule

@@ rtl/core/kmcr_controller.sv @@
module kmcr_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  kmcr_pkg::kmcr_status_t status,
    output kmcr_pkg::kmcr_cmd_t    cmd
);
    import kmcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Accept only while idle; walk while the output side has room
    assign in_stall = (state_reg != ST_IDLE);
    assign cmd.load = (state_reg == ST_IDLE) && in_valid;
    assign cmd.step = (state_reg == ST_WALK) && !status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && status.any_change)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (cmd.step && status.rest_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/kmcr_checker.sv @@
module kmcr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [kmcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [kmcr_pkg::KEYMAP_W-1:0]    cfg_data,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [kmcr_pkg::ROW_W-1:0]       rows_column0,
    input logic [kmcr_pkg::ROW_W-1:0]       rows_column1,
    input logic [kmcr_pkg::ROW_W-1:0]       rows_column2,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [kmcr_pkg::CODE_W-1:0]      key_code,
    input logic                             pressed,
    input logic                             last_event
);

    // Hold a stalled event
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key_code)
                                   && $stable(pressed) && $stable(last_event))
        else $error("stalled event changed");

    // Stay busy while more events of the scan remain
    a_busy_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_event |-> in_stall)
        else $error("new item accepted before scan finished");

    // Never report an unmapped position
    a_mapped_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_code != '0)
        else $error("event with unmapped key code");

    // Take register writes at once
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write not taken");

endmodule

bind keypad_matrix_change_reporter kmcr_checker u_kmcr_checker (.*);

@@ sim/keypad_matrix_change_reporter_checker.sv @@
module keypad_matrix_change_reporter_checker #(
    parameter int ROW_COUNT    = kmcr_pkg::ROW_COUNT_DEFAULT,
    parameter int COLUMN_COUNT = kmcr_pkg::COL_COUNT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [kmcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kmcr_pkg::KEYMAP_W-1:0]    cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [kmcr_pkg::ROW_W-1:0]       rows_column0,
    input  logic [kmcr_pkg::ROW_W-1:0]       rows_column1,
    input  logic [kmcr_pkg::ROW_W-1:0]       rows_column2,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [kmcr_pkg::CODE_W-1:0]      key_code,
    input  logic                             pressed,
    input  logic                             last_event,
    output int                               mismatch_count,
    output int                               pending_events
);

    import kmcr_pkg::*;

    localparam int HOME_ROW = 0;

    typedef struct packed {
        code_t code;
        logic  is_pressed;
        logic  is_last;
    } key_event_t;

    // Shadow of the block: keymaps, previous scan and home polarity
    keymap_t    keymap_copy [MAX_COLS];
    rows_t      prev_scan [MAX_COLS];
    mode_t      home_mode;
    key_event_t expected_events [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic apply_keymap_write(input logic [CFG_INDEX_W-1:0] idx, input keymap_t data);
        case (idx)
            CFG_KEYMAP_COLUMN0: keymap_copy[0] = data;
            CFG_KEYMAP_COLUMN1: keymap_copy[1] = data;
            CFG_KEYMAP_COLUMN2: keymap_copy[2] = data;
            default: ;
        endcase
    endtask

    // Work out the key events one scan causes and queue them in order
    task automatic predict_key_events(input rows_t c0, input rows_t c1, input rows_t c2);
        rows_t      scan [MAX_COLS];
        code_t      code;
        logic       now_bit;
        logic       was_bit;
        logic       have_held;
        key_event_t held;
        scan[0]   = c0;
        scan[1]   = c1;
        scan[2]   = c2;
        have_held = 1'b0;
        held      = '0;

        // First scan picks the home key polarity; inverted mode flips it every scan
        case (home_mode)
            MODE_UNDECIDED:
            begin
                if (scan[0][HOME_ROW])
                begin
                    home_mode          = MODE_INVERT;
                    scan[0][HOME_ROW]  = ~scan[0][HOME_ROW];
                end
                else
                begin
                    home_mode = MODE_NORMAL;
                end
            end
            MODE_INVERT: scan[0][HOME_ROW] = ~scan[0][HOME_ROW];
            default: ;
        endcase

        // Walk column-major; hold back one event so the final one gets the marker
        for (int col = 0; col < COLUMN_COUNT && col < MAX_COLS; col++)
        begin
            for (int row = 0; row < ROW_COUNT && row < MAX_ROWS; row++)
            begin
                code    = keymap_copy[col][8*row +: 8];
                now_bit = scan[col][row];
                was_bit = prev_scan[col][row];
                if (code != '0 && now_bit != was_bit)
                begin
                    if (have_held)
                        expected_events.push_back(held);
                    held      = '{code: code, is_pressed: now_bit, is_last: 1'b0};
                    have_held = 1'b1;
                end
            end
            prev_scan[col] = scan[col];
        end
        if (have_held)
        begin
            held.is_last = 1'b1;
            expected_events.push_back(held);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        key_event_t want;
        if (!rst_n)
        begin
            keymap_copy[0] = KEYMAP_COLUMN0_RESET;
            keymap_copy[1] = KEYMAP_COLUMN1_RESET;
            keymap_copy[2] = KEYMAP_COLUMN2_RESET;
            for (int col = 0; col < MAX_COLS; col++)
                prev_scan[col] = '0;
            home_mode = MODE_UNDECIDED;
            expected_events.delete();
            mismatch_count = 0;
            pending_events = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_keymap_write(cfg_index, cfg_data);

            if (in_valid && !in_stall)
                predict_key_events(rows_column0, rows_column1, rows_column2);

            // Compare each delivered item with the oldest expected event
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("key event code %0h with none expected", key_code));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (key_code !== want.code)
                        report_mismatch($sformatf("key_code %0h, want %0h", key_code, want.code));
                    if (pressed !== want.is_pressed)
                        report_mismatch($sformatf("pressed %0b, want %0b for code %0h",
                                                  pressed, want.is_pressed, want.code));
                    if (last_event !== want.is_last)
                        report_mismatch($sformatf("last_event %0b, want %0b for code %0h",
                                                  last_event, want.is_last, want.code));
                end
            end
            pending_events = expected_events.size();
        end
    end

endmodule

@@ sim/keypad_matrix_change_reporter_tb.sv @@
module keypad_matrix_change_reporter_tb;

    import kmcr_pkg::*;

    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 70;

    // Index past the last keymap register; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } idle_regime_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [KEYMAP_W-1:0]    cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    rows_t                  rows_column0 = '0;
    rows_t                  rows_column1 = '0;
    rows_t                  rows_column2 = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    code_t                  key_code;
    logic                   pressed;
    logic                   last_event;

    int    mismatch_count;
    int    pending_events;
    int    send_idle_pct = 33;
    int    recv_idle_pct = 58;
    int    cycle_count   = 0;
    rows_t held_rows [MAX_COLS] = '{default: '0};

    keypad_matrix_change_reporter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rows_column0 (rows_column0),
        .rows_column1 (rows_column1),
        .rows_column2 (rows_column2),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_code     (key_code),
        .pressed      (pressed),
        .last_event   (last_event)
    );

    keypad_matrix_change_reporter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rows_column0   (rows_column0),
        .rows_column1   (rows_column1),
        .rows_column2   (rows_column2),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_code       (key_code),
        .pressed        (pressed),
        .last_event     (last_event),
        .mismatch_count (mismatch_count),
        .pending_events (pending_events)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // End the run if it hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic set_idling(input idle_regime_t regime);
        case (regime)
            IDLE_SEND_LIGHT:
            begin
                send_idle_pct <= 33;
                recv_idle_pct <= 58;
            end
            IDLE_SEND_HEAVY:
            begin
                send_idle_pct <= 58;
                recv_idle_pct <= 33;
            end
            default:
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
        endcase
    endtask

    // Offer one scan after a random gap and hold it until taken
    task automatic send_scan(input rows_t c0, input rows_t c1, input rows_t c2);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        rows_column0 <= c0;
        rows_column1 <= c1;
        rows_column2 <= c2;
        held_rows[0] = c0;
        held_rows[1] = c1;
        held_rows[2] = c2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input keymap_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load all three keymaps, then poke the unused index
    task automatic write_keymaps(input keymap_t k0, input keymap_t k1, input keymap_t k2);
        write_register(CFG_KEYMAP_COLUMN0, k0);
        write_register(CFG_KEYMAP_COLUMN1, k1);
        write_register(CFG_KEYMAP_COLUMN2, k2);
        write_register(CFG_UNUSED_INDEX, keymap_t'({$urandom(), $urandom()}));
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected event, then let any eventless scan finish
    task automatic wait_drained();
        @(negedge clk);
        while (pending_events != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        rows_t   walk [MAX_COLS];
        keymap_t k [MAX_COLS];
        int      roll;
        int      n_flips;
        int      col;
        int      row;

        set_idling(IDLE_SEND_LIGHT);
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans on the reset keymaps; first one picks the home polarity
        send_scan(rows_t'($urandom_range(0, 1)), '0, '0);
        send_scan('1, '1, '1);
        send_scan('0, '0, '0);
        send_scan('0, '0, '0);
        // change on an unmapped position only
        send_scan(5'b00010, '0, '0);
        // home key only
        send_scan(5'b00001, '0, '0);
        send_scan('0, '0, '0);
        for (col = 0; col < MAX_COLS; col++)
        begin
            for (row = 0; row < MAX_ROWS; row++)
            begin
                walk           = '{default: '0};
                walk[col][row] = 1'b1;
                send_scan(walk[0], walk[1], walk[2]);
            end
        end
        send_scan(5'b10101, 5'b01010, 5'b10101);
        send_scan(5'b01010, 5'b10101, 5'b01010);
        send_scan('1, '1, '1);
        in_valid <= 1'b0;
        wait_drained();

        // Random scans over a range of keymap settings and idling regimes
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            set_idling(idle_regime_t'(phase / 2));
            for (col = 0; col < MAX_COLS; col++)
            begin
                case (phase)
                    0: k[col] = '0;
                    1: k[col] = '1;
                    3:
                    begin
                        k[col] = keymap_t'({$urandom(), $urandom()});
                        for (int b = 0; b < MAX_ROWS; b++)
                            if ($urandom_range(0, 1) != 0)
                                k[col][8*b +: 8] = '0;
                    end
                    default: k[col] = keymap_t'({$urandom(), $urandom()});
                endcase
            end
            if (phase == 4)
                write_keymaps(KEYMAP_COLUMN0_RESET, KEYMAP_COLUMN1_RESET,
                              KEYMAP_COLUMN2_RESET);
            else
                write_keymaps(k[0], k[1], k[2]);

            repeat (ITEMS_PER_PHASE)
            begin
                walk = held_rows;
                roll = $urandom_range(0, 99);
                if (roll < 30)
                begin
                    for (col = 0; col < MAX_COLS; col++)
                        walk[col] = rows_t'($urandom());
                end
                else if (roll < 65)
                begin
                    n_flips = $urandom_range(1, 3);
                    repeat (n_flips)
                    begin
                        col            = $urandom_range(0, MAX_COLS - 1);
                        row            = $urandom_range(0, MAX_ROWS - 1);
                        walk[col][row] = ~walk[col][row];
                    end
                end
                else if (roll < 75)
                begin
                    for (col = 0; col < MAX_COLS; col++)
                        walk[col] = ~walk[col];
                end
                else if (roll < 80)
                begin
                    walk = '{default: '0};
                end
                else if (roll < 85)
                begin
                    walk = '{default: '1};
                end
                // otherwise repeat the previous scan unchanged
                send_scan(walk[0], walk[1], walk[2]);
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/kmcr_pkg.sv
rtl/core/kmcr_datapath.sv
rtl/core/kmcr_controller.sv
rtl/core/keypad_matrix_change_reporter.sv
rtl/core/kmcr_checker.sv
sim/keypad_matrix_change_reporter_checker.sv
sim/keypad_matrix_change_reporter_tb.sv
